FILE: hw/rtl/shs_pkg.sv
// Types, constants and helper functions shared by the SHA-256 stream hasher.
package shs_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hvec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_kind_t;

	typedef struct packed {
		logic      shift_msg;
		logic      shift_pad;
		pad_kind_t pad_kind;
		logic [2:0] len_idx;
		logic      load_vars;
		logic      do_round;
		logic      add_hash;
		logic      clear_all;
		logic [5:0] round;
		logic [2:0] word;
	} ctl_t;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	localparam hvec_t H_INIT = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam word_t ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sigma0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: hw/rtl/shs_round.sv
// Shared SHA-256 round unit: one compression round and one message schedule step.
module shs_round (
	input  shs_pkg::hvec_t vars,
	input  shs_pkg::word_t k,
	input  shs_pkg::word_t w0,
	input  shs_pkg::word_t w1,
	input  shs_pkg::word_t w9,
	input  shs_pkg::word_t w14,
	output shs_pkg::hvec_t vars_next,
	output shs_pkg::word_t w_next
);
	import shs_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	always_comb begin
		ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1  = vars[7] + big_sigma1(vars[4]) + ch + k + w0;
		t2  = big_sigma0(vars[0]) + maj;
		vars_next[7] = vars[6];
		vars_next[6] = vars[5];
		vars_next[5] = vars[4];
		vars_next[4] = vars[3] + t1;
		vars_next[3] = vars[2];
		vars_next[2] = vars[1];
		vars_next[1] = vars[0];
		vars_next[0] = t1 + t2;
		w_next = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
	end

endmodule

FILE: hw/rtl/shs_ctrl.sv
// Sequencer of the SHA-256 stream hasher: byte fill, padding, rounds and digest output.
module shs_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_has,
	input  logic         in_eom,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output shs_pkg::ctl_t ctl
);
	import shs_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] round_q, round_d;
	logic [2:0] word_q, word_d;
	logic       eom_q, eom_d;
	logic       mark_q, mark_d;
	logic       len_ok_q, len_ok_d;
	logic       last_blk_q, last_blk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			round_q    <= '0;
			word_q     <= '0;
			eom_q      <= 1'b0;
			mark_q     <= 1'b0;
			len_ok_q   <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			round_q    <= round_d;
			word_q     <= word_d;
			eom_q      <= eom_d;
			mark_q     <= mark_d;
			len_ok_q   <= len_ok_d;
			last_blk_q <= last_blk_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		round_d    = round_q;
		word_d     = word_q;
		eom_d      = eom_q;
		mark_d     = mark_q;
		len_ok_d   = len_ok_q;
		last_blk_d = last_blk_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		ctl           = '0;
		ctl.pad_kind  = PAD_ZERO;
		ctl.len_idx   = ~fill_q[2:0];
		ctl.round     = round_q;
		ctl.word      = word_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_has) begin
						ctl.shift_msg = 1'b1;
						fill_d = fill_q + 6'd1;
					end
					if (in_has && fill_q == FILL_LAST) begin
						ctl.load_vars = 1'b1;
						round_d = '0;
						eom_d   = in_eom;
						state_d = ST_ROUND;
					end else if (in_eom) begin
						eom_d   = 1'b1;
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				ctl.do_round = 1'b1;
				round_d = round_q + 6'd1;
				if (round_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				ctl.add_hash = 1'b1;
				word_d = '0;
				if (last_blk_q) begin
					state_d = ST_OUT;
				end else if (eom_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				ctl.shift_pad = 1'b1;
				fill_d = fill_q + 6'd1;
				if (!mark_q) begin
					ctl.pad_kind = PAD_MARK;
					mark_d = 1'b1;
				end else if (len_ok_q && fill_q >= LEN_START) begin
					ctl.pad_kind = PAD_LEN;
				end
				len_ok_d = (mark_q ? len_ok_q : (fill_q < LEN_START)) | (fill_q == FILL_LAST);
				if (fill_q == FILL_LAST) begin
					ctl.load_vars = 1'b1;
					round_d    = '0;
					last_blk_d = mark_q & len_ok_q;
					state_d    = ST_ROUND;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					word_d = word_q + 3'd1;
					if (word_q == WORD_LAST) begin
						ctl.clear_all = 1'b1;
						fill_d     = '0;
						eom_d      = 1'b0;
						mark_d     = 1'b0;
						len_ok_d   = 1'b0;
						last_blk_d = 1'b0;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: block shift line, hash state and round unit.
// Each input transfer may append one message byte (tuser high) and may close the message
// (tlast high). A transfer that only appends a byte leaves the input ready. A transfer that
// fills the 64-byte block holds the input off while the single round unit runs one of the 64
// rounds per cycle and an add step then adds the result into the hash words. A closing
// transfer then shifts the padding and length into the block one byte per cycle, needing one
// or two further compressions, after which the eight digest words leave as eight
// output transfers, word 0 first with tlast on word 7; the input stays closed until the last
// of them is taken, and the hash then starts again from its initial value.
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);
	import shs_pkg::*;

	ctl_t          ctl;
	logic [511:0]  blk_q;
	hvec_t         vars_q;
	hvec_t         hash_q;
	hvec_t         vars_next;
	word_t         w_next;
	logic [60:0]   byte_cnt_q;
	logic [63:0]   len_bits;
	logic [7:0]    pad_byte;

	shs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_has    (s_axis_tuser),
		.in_eom    (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	shs_round u_round (
		.vars      (vars_q),
		.k         (ROUND_K[ctl.round]),
		.w0        (blk_q[511:480]),
		.w1        (blk_q[479:448]),
		.w9        (blk_q[223:192]),
		.w14       (blk_q[63:32]),
		.vars_next (vars_next),
		.w_next    (w_next)
	);

	assign len_bits = {byte_cnt_q, 3'b000};

	always_comb begin
		unique case (ctl.pad_kind)
			PAD_MARK: pad_byte = PAD_MARK_BYTE;
			PAD_LEN:  pad_byte = len_bits[{ctl.len_idx, 3'b000} +: 8];
			default:  pad_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_msg) begin
			blk_q <= {blk_q[503:0], s_axis_tdata};
		end else if (ctl.shift_pad) begin
			blk_q <= {blk_q[503:0], pad_byte};
		end else if (ctl.do_round) begin
			blk_q <= {blk_q[479:0], w_next};
		end
		if (ctl.load_vars) begin
			vars_q <= hash_q;
		end else if (ctl.do_round) begin
			vars_q <= vars_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= H_INIT;
			byte_cnt_q <= '0;
		end else begin
			if (ctl.clear_all) begin
				hash_q     <= H_INIT;
				byte_cnt_q <= '0;
			end else begin
				if (ctl.add_hash) begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + vars_q[i];
					end
				end
				if (ctl.shift_msg) begin
					byte_cnt_q <= byte_cnt_q + 61'd1;
				end
			end
		end
	end

	assign m_axis_tdata = hash_q[ctl.word];
	assign m_axis_tuser = ctl.word;
	assign m_axis_tlast = (ctl.word == WORD_LAST);

`ifndef NO_ASSERTIONS
	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("Input accepted while the digest is being sent.");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
		else $error("Digest words are not sent in consecutive order.");

	a_ready_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
		(s_axis_tready && !m_axis_tvalid))
		else $error("Hasher did not return to idle after the final digest word.");
`endif

endmodule
